FILE: rtl/core/urfi_pkg.sv
// Shared types and constants for the UART register block with receive FIFO.
// Used by the top level uart_regs_rx_fifo_irq and by its port checker.
// No dependencies.
package urfi_pkg;

  // Receive ring geometry
  localparam int unsigned RxDepth = 16;
  localparam int unsigned IdxW    = $clog2(RxDepth);
  localparam int unsigned CntW    = $clog2(RxDepth + 1);
  // Width used for trigger-level compares (covers counts up to 255)
  localparam int unsigned CmpW    = 8;

  // Stream payload widths
  localparam int unsigned InDataW  = 56;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 32;

  // Output word bit positions
  localparam int unsigned OutRxIrq   = 16;
  localparam int unsigned OutTxIrq   = 17;
  localparam int unsigned OutErrIrq  = 18;
  localparam int unsigned OutDmaReq  = 19;
  localparam int unsigned OutTxValid = 20;
  localparam int unsigned OutTxLo    = 21;
  localparam int unsigned OutTxHi    = 28;

  // Item kinds
  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_RX    = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  // Register offsets
  localparam logic [11:0] AddrLineCtrl  = 12'h000;
  localparam logic [11:0] AddrMainCtrl  = 12'h004;
  localparam logic [11:0] AddrFifoCtrl  = 12'h008;
  localparam logic [11:0] AddrModemCtrl = 12'h00c;
  localparam logic [11:0] AddrTrxStat   = 12'h010;
  localparam logic [11:0] AddrErrStat   = 12'h014;
  localparam logic [11:0] AddrFifoStat  = 12'h018;
  localparam logic [11:0] AddrModemStat = 12'h01c;
  localparam logic [11:0] AddrTxBuf     = 12'h020;
  localparam logic [11:0] AddrRxBuf     = 12'h024;
  localparam logic [11:0] AddrBaud      = 12'h028;

  // Write masks and fixed read values
  localparam logic [10:0] MaskMainCtrl  = 11'h7ef;
  localparam logic [7:0]  MaskFifoCtrl  = 8'hf1;
  localparam logic [4:0]  MaskModemCtrl = 5'h11;
  localparam logic [15:0] ModemStatVal  = 16'h0011;
  localparam logic [15:0] TrxStatBase   = 16'h0006;
  localparam logic [15:0] FifoStatFlag  = 16'h0100;

  // Interrupt/DMA mode codes
  localparam logic [1:0] ModeIrq = 2'd1;

  // Sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_POP
  } state_e;

endpackage

FILE: rtl/core/uart_regs_rx_fifo_irq.sv
// Top level of the UART register block: registers, receive ring and pulse logic.
// Depends on urfi_pkg for constants and types; the ring is an internal memory.
//
// Usage:
//   One input word on the s_axis side is a bus read, a bus write or one byte
//   from the serial line, selected by s_axis_tuser. Every input word gives
//   exactly one output word on the m_axis side with the read data, the
//   interrupt and DMA pulses and the transmit byte.
//   Most words go straight into the output register on acceptance; a
//   receive-buffer read that pops a byte from the ring passes through the
//   registered ring read port and the ST_POP state before m_axis_tvalid.
//   Throughput: one word per cycle while the output is not stalled, except a
//   FIFO pop, which holds the input in ST_POP while the ring read completes.
//   The result sits in an output register; a new input word is taken in the
//   same cycle that the previous result is taken. While the receiver stalls
//   the output, s_axis_tready stays low and the held result is stable.
//   Reset clears all control registers, the ring head and count and the
//   overrun flag; ring contents stay undefined until written, so no clearing
//   pass is needed and the block is ready right after reset.
module uart_regs_rx_fifo_irq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: addr[11:0], write_data[43:12], rx_byte[51:44], zero pad [55:52]
  input  logic [urfi_pkg::InDataW-1:0]  s_axis_tdata,
  // tuser: kind[1:0]
  input  logic [urfi_pkg::InUserW-1:0]  s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: read_data[15:0], rx_irq[16], tx_irq[17], err_irq[18], dma_req[19],
  //        tx_valid[20], tx_data[28:21], zero pad [31:29]
  output logic [urfi_pkg::OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned IdxW = urfi_pkg::IdxW;
  localparam int unsigned CntW = urfi_pkg::CntW;
  localparam int unsigned CmpW = urfi_pkg::CmpW;

  // Input fields
  urfi_pkg::kind_e kind;
  logic [11:0]     addr;
  logic [31:0]     wdata;
  logic [7:0]      rx_byte;

  assign kind    = urfi_pkg::kind_e'(s_axis_tuser);
  assign addr    = s_axis_tdata[11:0];
  assign wdata   = s_axis_tdata[43:12];
  assign rx_byte = s_axis_tdata[51:44];

  // State registers
  urfi_pkg::state_e state_q, state_d;
  logic [7:0]      line_q, line_d;
  logic [10:0]     main_q, main_d;
  logic [7:0]      fifo_q, fifo_d;
  logic [4:0]      modem_q, modem_d;
  logic [15:0]     baud_q, baud_d;
  logic            ovr_q, ovr_d;
  logic [IdxW-1:0] head_q, head_d;
  logic [CntW-1:0] count_q, count_d;
  logic [7:0]      hold_q, hold_d;

  // Output register
  logic            out_valid_q, out_valid_d;
  logic [15:0]     rdata_q;
  logic            rx_irq_q, tx_irq_q, err_irq_q, dma_q, txv_q;
  logic [7:0]      txd_q;

  // Ring memory
  logic [7:0]      ring_mem [urfi_pkg::RxDepth];
  logic [7:0]      ring_rd_q;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;

  logic accept;
  logic load_out;

  // Per-item decode results
  logic [15:0] rdata;
  logic        reeval, tx_pulse, rx_eval, rx_pulse, err_set;
  logic        txv;
  logic [7:0]  txd;
  logic        pop_mem;
  logic        rx_irq, tx_irq, err_irq, dma;

  // Ring write index and head advance
  logic [CntW:0]   wr_sum;
  logic [IdxW-1:0] head_inc;

  always_comb begin
    wr_sum = (CntW + 1)'(head_q) + (CntW + 1)'(count_q);
    if (wr_sum >= (CntW + 1)'(urfi_pkg::RxDepth)) begin
      wr_sum = wr_sum - (CntW + 1)'(urfi_pkg::RxDepth);
    end
    mem_waddr = wr_sum[IdxW-1:0];
    if (head_q == IdxW'(urfi_pkg::RxDepth - 1)) begin
      head_inc = '0;
    end else begin
      head_inc = head_q + IdxW'(1);
    end
  end

  // Register access and receive decode
  always_comb begin
    line_d    = line_q;
    main_d    = main_q;
    fifo_d    = fifo_q;
    modem_d   = modem_q;
    baud_d    = baud_q;
    ovr_d     = ovr_q;
    head_d    = head_q;
    count_d   = count_q;
    hold_d    = hold_q;
    rdata     = '0;
    reeval    = 1'b0;
    tx_pulse  = 1'b0;
    rx_eval   = 1'b0;
    rx_pulse  = 1'b0;
    err_set   = 1'b0;
    txv       = 1'b0;
    txd       = '0;
    pop_mem   = 1'b0;
    mem_we    = 1'b0;
    unique case (kind)
      urfi_pkg::KIND_READ: begin
        unique case (addr)
          urfi_pkg::AddrLineCtrl:  rdata = 16'(line_q);
          urfi_pkg::AddrMainCtrl:  rdata = 16'(main_q);
          urfi_pkg::AddrFifoCtrl:  rdata = 16'(fifo_q);
          urfi_pkg::AddrModemCtrl: rdata = 16'(modem_q);
          urfi_pkg::AddrTrxStat: begin
            rdata = urfi_pkg::TrxStatBase | 16'(count_q != '0);
          end
          urfi_pkg::AddrErrStat: begin
            rdata  = 16'(ovr_q);
            ovr_d  = 1'b0;
            reeval = 1'b1;
          end
          urfi_pkg::AddrFifoStat: begin
            reeval = 1'b1;
            if (count_q != '0) begin
              rdata = 16'(count_q) | urfi_pkg::FifoStatFlag;
            end
          end
          urfi_pkg::AddrModemStat: begin
            reeval = 1'b1;
            rdata  = urfi_pkg::ModemStatVal;
          end
          urfi_pkg::AddrRxBuf: begin
            reeval = 1'b1;
            if (count_q != '0) begin
              count_d = count_q - CntW'(1);
              if (fifo_q[0]) begin
                pop_mem = 1'b1;
                head_d  = head_inc;
              end else begin
                rdata = 16'(hold_q);
              end
            end
          end
          urfi_pkg::AddrBaud: rdata = baud_q;
          default: rdata = '0;
        endcase
      end
      urfi_pkg::KIND_WRITE: begin
        unique case (addr)
          urfi_pkg::AddrLineCtrl: begin
            line_d = wdata[7:0];
            reeval = 1'b1;
          end
          urfi_pkg::AddrMainCtrl: begin
            main_d = wdata[10:0] & urfi_pkg::MaskMainCtrl;
            reeval = 1'b1;
          end
          urfi_pkg::AddrFifoCtrl: begin
            if (wdata[1]) begin
              count_d = '0;
            end
            fifo_d = wdata[7:0] & urfi_pkg::MaskFifoCtrl;
            reeval = 1'b1;
          end
          urfi_pkg::AddrModemCtrl: begin
            modem_d = wdata[4:0] & urfi_pkg::MaskModemCtrl;
            reeval  = 1'b1;
          end
          urfi_pkg::AddrTxBuf: begin
            txv      = 1'b1;
            txd      = wdata[7:0];
            tx_pulse = 1'b1;
            reeval   = 1'b1;
          end
          urfi_pkg::AddrBaud: begin
            baud_d = wdata[15:0];
            reeval = 1'b1;
          end
          default: reeval = 1'b0;
        endcase
      end
      urfi_pkg::KIND_RX: begin
        rx_eval  = 1'b1;
        rx_pulse = 1'b1;
        if (fifo_q[0]) begin
          if (count_q >= CntW'(urfi_pkg::RxDepth)) begin
            err_set = 1'b1;
          end else begin
            mem_we  = accept;
            count_d = count_q + CntW'(1);
          end
        end else begin
          if (count_q != '0) begin
            err_set = 1'b1;
          end
          count_d = CntW'(1);
          hold_d  = rx_byte;
        end
      end
      default: begin
        reeval = 1'b0;
      end
    endcase
    if (err_set) begin
      ovr_d = 1'b1;
    end
  end

  // Interrupt and DMA pulse logic on the evaluated state
  logic [CntW-1:0] count_e;
  logic [CmpW-1:0] trig;
  logic            tx_on, rx_on, rx_quiet;
  logic [1:0]      tmode, rmode;

  always_comb begin
    // Reads evaluate before any pop; writes and receives after the update
    count_e  = (kind == urfi_pkg::KIND_READ) ? count_q : count_d;
    trig     = (CmpW'(fifo_d[5:4]) + CmpW'(1)) << 2;
    tmode    = main_d[3:2];
    rmode    = main_d[1:0];
    tx_on    = reeval | tx_pulse;
    rx_on    = reeval | rx_eval;
    rx_quiet = fifo_d[0] && (CmpW'(count_e) < trig) &&
               ((rmode != urfi_pkg::ModeIrq) || (count_e == '0) || !main_d[7]);
    tx_irq   = tx_on && (tmode == urfi_pkg::ModeIrq) && (main_d[9] || tx_pulse);
    rx_irq   = rx_on && !rx_quiet && (rmode == urfi_pkg::ModeIrq) &&
               (main_d[8] || rx_pulse);
    dma      = (tx_on && tmode[1]) || (rx_on && !rx_quiet && rmode[1]);
    err_irq  = err_set && main_q[6];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      urfi_pkg::ST_IDLE: begin
        if (accept && pop_mem) begin
          state_d = urfi_pkg::ST_POP;
        end
      end
      urfi_pkg::ST_POP: state_d = urfi_pkg::ST_IDLE;
      default:          state_d = urfi_pkg::ST_IDLE;
    endcase
  end

  // Handshake and output register control
  always_comb begin
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    out_valid_d   = out_valid_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      urfi_pkg::ST_IDLE: begin
        s_axis_tready = !out_valid_q || m_axis_tready;
        if (accept && !pop_mem) begin
          out_valid_d = 1'b1;
        end
      end
      urfi_pkg::ST_POP: begin
        load_out    = 1'b1;
        out_valid_d = 1'b1;
      end
      default: s_axis_tready = 1'b0;
    endcase
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= urfi_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      line_q      <= '0;
      main_q      <= '0;
      fifo_q      <= '0;
      modem_q     <= '0;
      baud_q      <= '0;
      ovr_q       <= 1'b0;
      head_q      <= '0;
      count_q     <= '0;
      hold_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        line_q  <= line_d;
        main_q  <= main_d;
        fifo_q  <= fifo_d;
        modem_q <= modem_d;
        baud_q  <= baud_d;
        ovr_q   <= ovr_d;
        head_q  <= head_d;
        count_q <= count_d;
        hold_q  <= hold_d;
      end
    end
  end

  // Result payload; a FIFO pop fills read data from the ring read register in ST_POP
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rdata_q   <= rdata;
      rx_irq_q  <= rx_irq;
      tx_irq_q  <= tx_irq;
      err_irq_q <= err_irq;
      dma_q     <= dma;
      txv_q     <= txv;
      txd_q     <= txd;
    end else if (load_out) begin
      rdata_q <= 16'(ring_rd_q);
    end
  end

  // Receive ring: one write port, registered read at the head
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= rx_byte;
    end
    if (accept && pop_mem) begin
      ring_rd_q <= ring_mem[head_q];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, txd_q, txv_q, dma_q, err_irq_q, tx_irq_q, rx_irq_q, rdata_q};

endmodule

FILE: rtl/core/urfi_chk.sv
// Port checker for uart_regs_rx_fifo_irq, attached by the bind below.
// Depends on urfi_pkg for the output word layout.
module urfi_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [urfi_pkg::OutDataW-1:0] m_axis_tdata
);

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("output word changed while stalled");

  // Input is never taken while a result is stuck at the output
  a_no_take_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input ready while output stalled");

  // Transmit byte reads zero without the transmit flag
  a_txd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[urfi_pkg::OutTxValid]) |->
      (m_axis_tdata[urfi_pkg::OutTxHi:urfi_pkg::OutTxLo] == 8'h00))
    else $error("tx_data set without tx_valid");

  // A transmit write returns no read data and no error pulse
  a_tx_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[urfi_pkg::OutTxValid]) |->
      ((m_axis_tdata[15:0] == 16'h0000) && !m_axis_tdata[urfi_pkg::OutErrIrq]))
    else $error("read data or error pulse on a transmit write");

  // An accepted word gives a result on m_axis_tvalid, also when it pops the FIFO
  a_result_soon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> ##1 (m_axis_tvalid || $past(m_axis_tvalid)))
    else $error("no result after an accepted word");

endmodule

bind uart_regs_rx_fifo_irq urfi_chk u_urfi_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
